FILE: rtl/adq_pkg.sv
package adq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int CNT_W     = 5;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP_REAR   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

FILE: rtl/adq_ram.sv
module adq_ram #(
  parameter int DEPTH = adq_pkg::DEPTH_DEF,
  parameter int WIDTH = adq_pkg::DATA_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: rtl/array_double_ended_queue_unit.sv
// Linear array deque. Each input beat carries one operation in in_tuser (push rear, push
// front, pop rear, pop front) and a push value in in_tdata; each produces exactly one
// result beat with status, empty flag, entry count and the first and last values after
// the operation (zero when empty). Both indices start at -1, so front pushes only succeed
// after front pops have freed slots. An accepted item updates the indices and writes the
// slot memory; in the read state, once the output register is free, the new first and
// last slots are read through the memory's registered read ports straight into the
// output register. A new item is taken while a finished result waits on out_tready, but
// not while the last item is still in the read state. capacity (cfg_wr_data) limits rear
// pushes and saturates at DEPTH; write it only while the block is idle.
module array_double_ended_queue_unit #(
  parameter int DEPTH = adq_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [adq_pkg::CAP_W-1:0]  cfg_wr_data,  // capacity
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,     // [31:0] push_value
  input  logic [1:0]                 in_tuser,     // [1:0] action
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [1:0] status, [2] is_empty, [7:3] entry_count, [39:8] first_value, [71:40] last_value
  output logic [71:0]                out_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = $clog2(DEPTH + 1) + 1;
  localparam int CW = IW + adq_pkg::CAP_W;
  localparam int DW = (IW > adq_pkg::CNT_W) ? IW : adq_pkg::CNT_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                          state_r, state_nxt;
  logic signed [IW-1:0]          front_r, front_nxt;
  logic signed [IW-1:0]          rear_r, rear_nxt;
  logic [adq_pkg::CAP_W-1:0]     cap_r;
  logic [adq_pkg::STAT_W-1:0]    st_r, st_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [adq_pkg::STAT_W-1:0]    out_status_r;
  logic                          out_empty_r;
  logic [adq_pkg::CNT_W-1:0]     out_count_r;

  logic                          in_fire;
  logic                          load;
  logic                          cur_empty;
  logic signed [IW-1:0]          rear_p1;
  logic [CW-1:0]                 rear_p1_w;
  logic [CW-1:0]                 cap_w;
  logic [CW-1:0]                 eff_cap;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic signed [IW-1:0]          first_idx;
  logic signed [DW-1:0]          count_w;
  logic [adq_pkg::DATA_W-1:0]    rd_first;
  logic [adq_pkg::DATA_W-1:0]    rd_last;
  logic [adq_pkg::DATA_W-1:0]    first_val;
  logic [adq_pkg::DATA_W-1:0]    last_val;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign load      = (state_r == S_READ) && (!out_valid_r || out_tready);
  assign cur_empty = (front_r == rear_r);

  // Capacity saturates at DEPTH; this also covers the DEPTH bound on rear pushes.
  assign rear_p1   = rear_r + IW'(1);
  assign rear_p1_w = CW'(unsigned'(rear_p1));
  assign cap_w     = CW'(cap_r);
  assign eff_cap   = (cap_w > CW'(DEPTH)) ? CW'(DEPTH) : cap_w;

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    st_nxt    = st_r;
    wr_en     = 1'b0;
    wr_addr   = rear_p1[AW-1:0];
    if (in_fire) begin
      st_nxt = adq_pkg::ST_DONE;
      case (in_tuser)
        adq_pkg::ACT_PUSH_REAR: begin
          if (rear_p1_w >= eff_cap) begin
            st_nxt = adq_pkg::ST_OVERFLOW;
          end else begin
            rear_nxt = rear_p1;
            wr_en    = 1'b1;
          end
        end
        adq_pkg::ACT_PUSH_FRONT: begin
          wr_addr = front_r[AW-1:0];
          if (front_r[IW-1]) begin
            st_nxt = adq_pkg::ST_OVERFLOW;
          end else begin
            front_nxt = front_r - IW'(1);
            wr_en     = 1'b1;
          end
        end
        adq_pkg::ACT_POP_REAR: begin
          if (cur_empty) begin
            st_nxt = adq_pkg::ST_UNDERFLOW;
          end else begin
            rear_nxt = rear_r - IW'(1);
          end
        end
        default: begin
          if (cur_empty) begin
            st_nxt = adq_pkg::ST_UNDERFLOW;
          end else begin
            front_nxt = front_r + IW'(1);
          end
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // hold until the output register frees up
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '1;
      rear_r      <= '1;
      cap_r       <= adq_pkg::CAP_RESET;
      st_r        <= adq_pkg::ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  assign first_idx = front_r + IW'(1);
  assign count_w   = DW'(rear_r) - DW'(front_r);

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= st_r;
      out_empty_r  <= cur_empty;
      out_count_r  <= count_w[adq_pkg::CNT_W-1:0];
    end
  end

  adq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (adq_pkg::DATA_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_tdata),
    .rd_en     (load),
    .rd_addr_a (first_idx[AW-1:0]),
    .rd_addr_b (rear_r[AW-1:0]),
    .rd_data_a (rd_first),
    .rd_data_b (rd_last)
  );

  // empty deque reports zero for both ends
  assign first_val = out_empty_r ? '0 : rd_first;
  assign last_val  = out_empty_r ? '0 : rd_last;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {last_val, first_val, out_count_r, out_empty_r, out_status_r};

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (front_r <= rear_r) && (rear_r < IW'(DEPTH)))
    else $error("deque indices out of order or out of range");

  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (st_r == adq_pkg::ST_DONE) ||
                (front_r == $past(front_r) && rear_r == $past(rear_r)))
    else $error("refused operation moved an index");

  a_rear_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == adq_pkg::ACT_PUSH_REAR) |=>
      (st_r != adq_pkg::ST_DONE) || (rear_r == $past(rear_r) + IW'(1)))
    else $error("rear push did not advance rear index");

  a_no_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_IDLE) || !$past(load))
    else $error("result load lost");

endmodule

FILE: sim/array_double_ended_queue_unit_tb.sv
`timescale 1ns / 1ps

module array_double_ended_queue_unit_tb;

  localparam int DEPTH = adq_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  // Operation mixes for the random part
  typedef enum int {MIX_GROW, MIX_DRAIN, MIX_FRONT, MIX_UNIFORM} op_mix_t;

  // Same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [adq_pkg::DATA_W-1:0] last_value;
    logic [adq_pkg::DATA_W-1:0] first_value;
    logic [adq_pkg::CNT_W-1:0]  entry_count;
    logic                       is_empty;
    logic [adq_pkg::STAT_W-1:0] status;
  } deque_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [adq_pkg::CAP_W-1:0]  cfg_wr_data;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [31:0]                in_tdata;   // [31:0] push_value
  logic [1:0]                 in_tuser;   // [1:0] action
  logic                       out_tvalid;
  logic                       out_tready;
  // [1:0] status, [2] is_empty, [7:3] entry_count, [39:8] first_value, [71:40] last_value
  logic [71:0]                out_tdata;

  // Deque state mirrored by the testbench
  logic [adq_pkg::DATA_W-1:0] slot_mem [DEPTH];
  int                         front_idx = -1;
  int                         rear_idx = -1;
  logic [adq_pkg::CAP_W-1:0]  capacity_reg = adq_pkg::CAP_RESET;

  deque_result_t       pending_results [$];
  int                  mismatches = 0;
  int                  n_ops = 0;
  int                  n_results = 0;
  int                  n_overflow = 0;
  int                  n_underflow = 0;
  int                  n_cfg = 0;
  int                  cycles = 0;
  int                  hold_cycles = 0;
  bit                  gap_en = 1'b0;
  bit                  stall_en = 1'b0;

  array_double_ended_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the mirrored deque and return what the block must report
  function automatic deque_result_t deque_apply(logic [1:0] act,
                                                logic [adq_pkg::DATA_W-1:0] val);
    deque_result_t r;
    int lim;
    bit was_empty;
    lim = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
    was_empty = (front_idx == rear_idx);
    r.status = adq_pkg::ST_DONE;
    case (act)
      adq_pkg::ACT_PUSH_REAR: begin
        if (rear_idx + 1 >= lim) begin
          r.status = adq_pkg::ST_OVERFLOW;
        end else begin
          rear_idx++;
          slot_mem[rear_idx] = val;
        end
      end
      adq_pkg::ACT_PUSH_FRONT: begin
        if (front_idx < 0) begin
          r.status = adq_pkg::ST_OVERFLOW;
        end else begin
          slot_mem[front_idx] = val;
          front_idx--;
        end
      end
      adq_pkg::ACT_POP_REAR: begin
        if (was_empty) r.status = adq_pkg::ST_UNDERFLOW;
        else rear_idx--;
      end
      default: begin
        if (was_empty) r.status = adq_pkg::ST_UNDERFLOW;
        else front_idx++;
      end
    endcase
    r.is_empty = (front_idx == rear_idx);
    r.entry_count = adq_pkg::CNT_W'(rear_idx - front_idx);
    r.first_value = r.is_empty ? '0 : slot_mem[front_idx + 1];
    r.last_value = r.is_empty ? '0 : slot_mem[rear_idx];
    return r;
  endfunction

  function automatic logic [1:0] pick_action(op_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:
        return (r < 60) ? adq_pkg::ACT_PUSH_REAR : (r < 75) ? adq_pkg::ACT_POP_FRONT :
               (r < 90) ? adq_pkg::ACT_PUSH_FRONT : adq_pkg::ACT_POP_REAR;
      MIX_DRAIN:
        return (r < 40) ? adq_pkg::ACT_POP_FRONT : (r < 80) ? adq_pkg::ACT_POP_REAR :
               (r < 90) ? adq_pkg::ACT_PUSH_REAR : adq_pkg::ACT_PUSH_FRONT;
      MIX_FRONT:
        return (r < 45) ? adq_pkg::ACT_POP_FRONT : (r < 90) ? adq_pkg::ACT_PUSH_FRONT :
               (r < 95) ? adq_pkg::ACT_PUSH_REAR : adq_pkg::ACT_POP_REAR;
      default:
        return 2'($urandom_range(0, 3));
    endcase
  endfunction

  // Predict on every accepted input beat
  always @(posedge clk) begin
    deque_result_t r;
    if (rst_n && in_tvalid && in_tready) begin
      r = deque_apply(in_tuser, in_tdata);
      if (r.status == adq_pkg::ST_OVERFLOW) n_overflow++;
      if (r.status == adq_pkg::ST_UNDERFLOW) n_underflow++;
      n_ops++;
      pending_results.push_back(r);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %h, got %h", n_results, name, exp_v, got_v);
    end
  endtask

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = deque_result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing predicted: %h", n_results, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        check_field("first_value", want.first_value, got.first_value);
        check_field("last_value", want.last_value, got.last_value);
      end
      n_results++;
    end
  end

  // Result side: long hold when asked, random short stalls when stalls are enabled
  initial begin : result_sink
    int n;
    out_tready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (stall_en && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("simulation failed");
    $finish;
  end

  task automatic send_op(input logic [1:0] act, input logic [31:0] val);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= val;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic set_capacity(input logic [adq_pkg::CAP_W-1:0] cap);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity_reg = cap;
    n_cfg++;
  endtask

  task automatic test_fresh_deque();
    send_op(adq_pkg::ACT_POP_REAR, 32'h0000_0000);
    send_op(adq_pkg::ACT_POP_FRONT, 32'hFFFF_FFFF);
    send_op(adq_pkg::ACT_PUSH_FRONT, 32'h1234_5678);
    settle();
  endtask

  task automatic test_value_extremes();
    send_op(adq_pkg::ACT_PUSH_REAR, 32'h8000_0000);
    send_op(adq_pkg::ACT_PUSH_REAR, 32'h7FFF_FFFF);
    send_op(adq_pkg::ACT_PUSH_REAR, 32'hFFFF_FFFF);
    send_op(adq_pkg::ACT_PUSH_REAR, 32'h0000_0000);
    send_op(adq_pkg::ACT_POP_FRONT, 32'h0000_0000);
    send_op(adq_pkg::ACT_POP_FRONT, 32'h0000_0000);
    send_op(adq_pkg::ACT_PUSH_FRONT, 32'h0000_0001);
    send_op(adq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFE);
    // front index is back at -1: refused
    send_op(adq_pkg::ACT_PUSH_FRONT, 32'hA5A5_A5A5);
    send_op(adq_pkg::ACT_POP_REAR, 32'h5A5A_5A5A);
    settle();
  endtask

  task automatic test_capacity_limits();
    set_capacity(5'd16);
    repeat (3) send_op(adq_pkg::ACT_PUSH_REAR, $urandom);
    settle();
    // shrink below the fill level: entries stay, rear pushes refused
    set_capacity(5'd2);
    send_op(adq_pkg::ACT_PUSH_REAR, $urandom);
    send_op(adq_pkg::ACT_POP_REAR, $urandom);
    send_op(adq_pkg::ACT_POP_REAR, $urandom);
    send_op(adq_pkg::ACT_PUSH_REAR, $urandom);
    settle();
    set_capacity(5'd0);
    send_op(adq_pkg::ACT_PUSH_REAR, $urandom);
    settle();
    set_capacity(5'd1);
    send_op(adq_pkg::ACT_PUSH_REAR, $urandom);
    send_op(adq_pkg::ACT_POP_FRONT, $urandom);
    settle();
  endtask

  task automatic test_input_stall();
    gap_en = 1'b0;
    set_capacity(5'd16);
    hold_cycles = 80;
    for (int i = 0; i < 16; i++) send_op(pick_action(MIX_GROW), $urandom);
    settle();
    gap_en = 1'b1;
  endtask

  task automatic test_random_ops(input logic [adq_pkg::CAP_W-1:0] cap, input int n_items);
    op_mix_t mix;
    int left;
    mix = MIX_GROW;
    left = 0;
    set_capacity(cap);
    for (int i = 0; i < n_items; i++) begin
      if (left == 0) begin
        mix = op_mix_t'($urandom_range(0, 3));
        left = $urandom_range(8, 40);
      end
      left--;
      send_op(pick_action(mix), $urandom);
    end
    settle();
  endtask

  task automatic test_quiet_finish();
    gap_en = 1'b0;
    stall_en = 1'b0;
    test_random_ops(5'd16, 300);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_en = 1'b1;
    stall_en = 1'b1;

    test_fresh_deque();
    test_value_extremes();
    test_capacity_limits();
    test_input_stall();
    test_random_ops(5'd16, 400);
    test_random_ops(5'd31, 300);
    test_random_ops(5'd0, 100);
    test_random_ops(5'd1, 150);
    for (int k = 0; k < 3; k++) test_random_ops(5'($urandom_range(2, 15)), 150);
    test_quiet_finish();

    $display("ran %0d deque operations (%0d overflow, %0d underflow refusals), %0d results",
             n_ops, n_overflow, n_underflow, n_results);
    $display("capacity written %0d times, extremes 0, 1, 16 and 31 included; %0d mismatches",
             n_cfg, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
